[rtl/multi_timer_scheduler_top_defines.svh]
// Assertion macros used by the timer scheduler top module.
`ifndef MULTI_TIMER_SCHEDULER_TOP_DEFINES_SVH
`define MULTI_TIMER_SCHEDULER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define MTS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MTS_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MTS_ASSERT(label, clk, rst_n, prop)
`define MTS_ASSERT_NR(label, clk, prop)
`endif
`endif

[rtl/mts_pkg.sv]
package mts_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotBits = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned IdBits = 16;
  localparam int unsigned TimeBits = 48;
  localparam int unsigned MaxFire = 32;
  localparam int unsigned FireBits = $clog2(MaxFire + 1);

  localparam logic [1:0] CmdRegister = 2'd0;
  localparam logic [1:0] CmdDestroy = 2'd1;
  localparam logic [1:0] CmdExists = 2'd2;
  localparam logic [1:0] CmdTick = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] delay;
    logic [31:0] period;
    logic [31:0] context_tag;
    logic [15:0] target_id;
  } req_t;

  typedef struct packed {
    logic        reply_kind;
    logic        ok;
    logic [15:0] tmr_id;
    logic [31:0] fired_tag;
    logic        last;
  } rsp_t;
endpackage

[rtl/mts_stream_if.sv]
interface mts_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/multi_timer_scheduler_top.sv]
// Timer queue with mts_pkg::Slots slots. Each command is one transaction in
// and at most 32 transactions out; the block takes no new command until the
// last result of the current one has been taken. Every scan walks the slot
// table one slot per cycle: register, destroy and exists scan it once, but
// register rescans the table once per id that is already in use. A tick
// that fires nothing returns to idle after one scan with no result; else it
// rescans the table after each fired timer, because each fired timer is held
// until the next scan shows whether it is the last one. Output stalls hold
// the block until each result is taken.
`include "multi_timer_scheduler_top_defines.svh"
module multi_timer_scheduler_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  mts_stream_if.sink   req_i,
  mts_stream_if.source rsp_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDone = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  localparam int unsigned SB = mts_pkg::SlotBits;
  localparam int unsigned IB = mts_pkg::IdBits;
  localparam int unsigned TB = mts_pkg::TimeBits;
  localparam int unsigned FB = mts_pkg::FireBits;

  logic [2:0] state_q, state_d;
  mts_pkg::req_t req_q;
  mts_pkg::rsp_t rsp_q;
  logic [TB-1:0] now_q;
  logic [IB-1:0] next_id_q;
  logic [mts_pkg::Slots-1:0] valid_q;
  logic [IB-1:0] ident_q [mts_pkg::Slots];
  logic [TB-1:0] dl_q [mts_pkg::Slots];
  logic [31:0] per_q [mts_pkg::Slots];
  logic [31:0] tag_q [mts_pkg::Slots];

  logic [SB:0] idx_q;
  logic found_q, free_found_q, id_hit_q;
  logic [SB-1:0] best_q, free_q;
  logic [FB-1:0] nfire_q;
  logic pend_q;
  logic held_q;

  logic [SB-1:0] cur;
  logic cur_due, better, id_match;
  logic [IB-1:0] want_id, id_inc;

  assign cur = idx_q[SB-1:0];
  assign want_id = (req_q.cmd == mts_pkg::CmdRegister) ? next_id_q
                 : IB'(req_q.target_id);
  assign id_match = valid_q[cur] && ident_q[cur] == want_id;
  assign cur_due = valid_q[cur] && dl_q[cur] <= now_q;
  assign better = !found_q || dl_q[cur] < dl_q[best_q]
               || (dl_q[cur] == dl_q[best_q] && ident_q[cur] < ident_q[best_q]);
  assign id_inc = (next_id_q + 1'b1 == '0) ? IB'(1) : next_id_q + 1'b1;

  assign req_i.ready = state_q == StIdle;
  assign rsp_o.valid = pend_q;
  assign rsp_o.data = rsp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (req_i.valid) state_d = StScan;
      StScan: if (idx_q == (SB+1)'(mts_pkg::Slots - 1)) state_d = StDone;
      StDone: state_d = StOut;
      StOut: if (!pend_q || rsp_o.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      req_q <= '0;
      rsp_q <= '0;
      now_q <= '0;
      next_id_q <= IB'(1);
      valid_q <= '0;
      for (int i = 0; i < mts_pkg::Slots; i++) begin
        ident_q[i] <= '0;
        dl_q[i] <= '0;
        per_q[i] <= '0;
        tag_q[i] <= '0;
      end
      pend_q <= 1'b0;
      held_q <= 1'b0;
      idx_q <= '0;
      found_q <= 1'b0;
      free_found_q <= 1'b0;
      id_hit_q <= 1'b0;
      best_q <= '0;
      free_q <= '0;
      nfire_q <= '0;
    end else begin
      if (pend_q && rsp_o.ready) pend_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            req_q <= req_i.data;
            idx_q <= '0;
            found_q <= 1'b0;
            free_found_q <= 1'b0;
            id_hit_q <= 1'b0;
            held_q <= 1'b0;
            nfire_q <= '0;
            if (req_i.data.cmd == mts_pkg::CmdTick) now_q <= now_q + 1'b1;
            state_q <= StScan;
          end
        end
        StScan: begin
          if (req_q.cmd == mts_pkg::CmdTick) begin
            if (cur_due && better) begin
              found_q <= 1'b1;
              best_q <= cur;
            end
          end else begin
            if (id_match) begin
              id_hit_q <= 1'b1;
              best_q <= cur;
            end
            if (!valid_q[cur] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_q <= cur;
            end
          end
          idx_q <= idx_q + 1'b1;
          state_q <= state_d;
        end
        StDone: begin
          unique case (req_q.cmd) inside
            mts_pkg::CmdRegister: begin
              if (!free_found_q) begin
                rsp_q.reply_kind <= 1'b0;
                rsp_q.ok <= 1'b0;
                rsp_q.tmr_id <= '0;
                rsp_q.fired_tag <= '0;
                rsp_q.last <= 1'b1;
                pend_q <= 1'b1;
                state_q <= StOut;
              end else if (id_hit_q) begin
                next_id_q <= id_inc;
                idx_q <= '0;
                id_hit_q <= 1'b0;
                free_found_q <= 1'b0;
                state_q <= StScan;
              end else begin
                next_id_q <= id_inc;
                valid_q[free_q] <= 1'b1;
                ident_q[free_q] <= next_id_q;
                dl_q[free_q] <= now_q + TB'(req_q.delay);
                per_q[free_q] <= req_q.period;
                tag_q[free_q] <= req_q.context_tag;
                rsp_q.reply_kind <= 1'b0;
                rsp_q.ok <= 1'b1;
                rsp_q.tmr_id <= 16'(next_id_q);
                rsp_q.fired_tag <= '0;
                rsp_q.last <= 1'b1;
                pend_q <= 1'b1;
                state_q <= StOut;
              end
            end
            mts_pkg::CmdDestroy, mts_pkg::CmdExists: begin
              if (req_q.cmd == mts_pkg::CmdDestroy && id_hit_q) valid_q[best_q] <= 1'b0;
              rsp_q.reply_kind <= 1'b0;
              rsp_q.ok <= id_hit_q;
              rsp_q.tmr_id <= req_q.target_id;
              rsp_q.fired_tag <= '0;
              rsp_q.last <= 1'b1;
              pend_q <= 1'b1;
              state_q <= StOut;
            end
            default: begin
              if (found_q && held_q) begin
                pend_q <= 1'b1;
                held_q <= 1'b0;
                state_q <= StOut;
              end else if (found_q) begin
                rsp_q.reply_kind <= 1'b1;
                rsp_q.ok <= 1'b1;
                rsp_q.tmr_id <= 16'(ident_q[best_q]);
                rsp_q.fired_tag <= tag_q[best_q];
                if (per_q[best_q] != '0) dl_q[best_q] <= dl_q[best_q] + TB'(per_q[best_q]);
                else valid_q[best_q] <= 1'b0;
                nfire_q <= nfire_q + 1'b1;
                if (nfire_q == FB'(mts_pkg::MaxFire - 1)) begin
                  rsp_q.last <= 1'b1;
                  pend_q <= 1'b1;
                  state_q <= StOut;
                end else begin
                  rsp_q.last <= 1'b0;
                  held_q <= 1'b1;
                  idx_q <= '0;
                  found_q <= 1'b0;
                  state_q <= StScan;
                end
              end else if (held_q) begin
                rsp_q.last <= 1'b1;
                pend_q <= 1'b1;
                held_q <= 1'b0;
                state_q <= StOut;
              end else begin
                state_q <= StIdle;
              end
            end
          endcase
        end
        StOut: begin
          if (!pend_q || rsp_o.ready) begin
            if (req_q.cmd == mts_pkg::CmdTick && !rsp_q.last) begin
              state_q <= StDone;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `MTS_ASSERT(a_ready_idle, clk_i, rst_ni, req_i.ready |-> !rsp_o.valid)
  `MTS_ASSERT(a_hold, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready |=> rsp_o.valid)
  `MTS_ASSERT(a_stable, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready |=> $stable(rsp_o.data))
  `MTS_ASSERT(a_fire_ok, clk_i, rst_ni, rsp_o.valid && rsp_o.data.reply_kind |-> rsp_o.data.ok)
endmodule
